[rtl/assert_macros.svh]
// assertion helpers shared by the acoustic wave stencil rtl
// expects clock and reset in scope where the short form is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// general form with explicit clock and reset
`define AWSS_ASSERT_AT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// short form on the module clock and reset
`define AWSS_ASSERT(lbl, prop, msg) \
   `AWSS_ASSERT_AT(lbl, clock, reset, prop, msg)

`endif

[rtl/awss_pkg.sv]
// shared types, constants and helpers for the acoustic wave stencil step
// no dependencies
package awss_pkg;

   localparam int MAX_COLS_DEF = 1024;
   localparam int MAX_ROWS_DEF = 1024;
   localparam int HALO         = 4;
   localparam int WIN_ROWS     = 2 * HALO + 1;
   localparam int LB_COUNT     = 2 * HALO;
   localparam int DLY_COUNT    = HALO;
   localparam int NPAIR        = HALO + 1;

   localparam int SAMPLE_W   = 32;
   localparam int IDX_W      = 10;
   localparam int DAMP_W     = 16;
   localparam int CMD_W      = 2;
   localparam int SIZE_W     = 11;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;
   localparam int REQ_DATA_W = 160;
   localparam int RSP_DATA_W = 88;
   localparam int DAMP_TAB   = 1024;

   localparam int PAIR_W = 33;
   localparam int COEF_W = 16;
   localparam int TERM_W = 49;
   localparam int SUM_W  = 52;
   localparam int PROD_W = 65;
   localparam int LAPP_W = 70;
   localparam int TPO_W  = 34;
   localparam int WIDE_W = 72;

   localparam logic [CMD_W-1:0] CMD_COL_DAMP = 2'd0;
   localparam logic [CMD_W-1:0] CMD_ROW_DAMP = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CELL     = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_GRID_COLS  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_GRID_ROWS  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SOURCE_ROW = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SOURCE_COL = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_SOURCE_SCL = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_LAP_SCL    = 3'd5;

   localparam logic [SIZE_W-1:0]     RESET_GRID  = 11'd1024;
   localparam logic [SAMPLE_W-1:0]   RESET_SCALE = 32'd65536;

   typedef logic signed [SAMPLE_W-1:0] sample_type;

   typedef struct packed {
      logic [SIZE_W-1:0]   grid_cols;
      logic [SIZE_W-1:0]   grid_rows;
      logic [IDX_W-1:0]    source_row;
      logic [IDX_W-1:0]    source_col;
      logic [SAMPLE_W-1:0] source_scale;
      logic [SAMPLE_W-1:0] lap_scale;
   } cfg_type;

   typedef struct packed {
      logic                          valid;
      logic [IDX_W-1:0]              row;
      logic [IDX_W-1:0]              col;
      logic [WIN_ROWS-1:0][SAMPLE_W-1:0] vert;
      logic [WIN_ROWS-1:0][SAMPLE_W-1:0] horz;
      logic [SAMPLE_W-1:0]           centre;
      logic [SAMPLE_W-1:0]           older;
      logic [SAMPLE_W-1:0]           velocity;
      logic [DAMP_W-1:0]             col_damp;
      logic [DAMP_W-1:0]             row_damp;
   } window_type;

   // symmetric eighth-order coefficients, outermost pair first, centre last
   function automatic logic signed [COEF_W-1:0] stencil_coef(input int k);
      logic signed [COEF_W-1:0] c;
      case (k)
         0:       c = -16'sd9;
         1:       c = 16'sd128;
         2:       c = -16'sd1008;
         3:       c = 16'sd8064;
         default: c = -16'sd14350;
      endcase
      return c;
   endfunction

   function automatic sample_type sat32(input logic signed [WIDE_W-1:0] x);
      logic [WIDE_W-32:0] upper;
      sample_type         r;
      upper = x[WIDE_W-1:31];
      if (&upper || ~|upper) begin
         r = x[SAMPLE_W-1:0];
      end else if (x[WIDE_W-1]) begin
         r = {1'b1, {(SAMPLE_W-1){1'b0}}};
      end else begin
         r = {1'b0, {(SAMPLE_W-1){1'b1}}};
      end
      return r;
   endfunction

endpackage

[rtl/awss_ram.sv]
// generic single-write, single-read ram with registered read data
// no dependencies
module awss_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/awss_front.sv]
// raster position, source injection, line stores and window registers
// depends on awss_pkg, awss_ram and assert_macros.svh
`include "assert_macros.svh"
module awss_front import awss_pkg::*; #(
   parameter int MAX_COLS = MAX_COLS_DEF,
   parameter int MAX_ROWS = MAX_ROWS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                adv,
   input  logic                req_acc,
   input  logic [CMD_W-1:0]    cmd,
   input  logic [IDX_W-1:0]    table_index,
   input  logic [DAMP_W-1:0]   damp_value,
   input  logic [SAMPLE_W-1:0] present_sample,
   input  logic [SAMPLE_W-1:0] older_sample,
   input  logic [SAMPLE_W-1:0] velocity_factor,
   input  logic [SAMPLE_W-1:0] wavelet_sample,
   input  cfg_type             cfg,
   output window_type          win
);

   localparam int CW    = $clog2(MAX_COLS);
   localparam int RW    = $clog2(MAX_ROWS);
   localparam int PW    = (CW > RW) ? CW : RW;
   localparam int CMP_W = ((PW > SIZE_W) ? PW : SIZE_W) + 1;

   logic [CMP_W-1:0] gcols, grows, cols, rows;
   logic [CW-1:0]    cur_col_ff, cur_col_in, c0;
   logic [RW-1:0]    cur_row_ff, cur_row_in, r0;
   logic             restart, col_last, row_last, cell_acc, is_src, emit0;
   logic [IDX_W-1:0] orow0, ocol0;
   logic signed [PROD_W-1:0] prod_in;

   // first stage after the transaction
   logic                     v1_ff, e1_ff, s1_ff;
   logic [CW-1:0]            c1_ff;
   sample_type               pres1_ff, older1_ff;
   logic [SAMPLE_W-1:0]      vel1_ff;
   logic signed [PROD_W-1:0] prod1_ff;
   logic [IDX_W-1:0]         orow1_ff, ocol1_ff;

   sample_type           p_inj;
   logic [SAMPLE_W-1:0]  lb_rd [LB_COUNT];
   logic [2*SAMPLE_W-1:0] dl_rd [DLY_COUNT];
   logic [DAMP_W-1:0]    col_rd, row_rd;
   sample_type           cv [WIN_ROWS];

   sample_type           vd_ff [DLY_COUNT][WIN_ROWS];
   sample_type           h_ff [LB_COUNT];
   logic [2*SAMPLE_W-1:0] od_ff [DLY_COUNT];
   window_type           win_ff, win_in;

   always_comb begin
      gcols = CMP_W'(cfg.grid_cols);
      grows = CMP_W'(cfg.grid_rows);
      if (gcols < CMP_W'(WIN_ROWS)) begin
         cols = CMP_W'(WIN_ROWS);
      end else if (gcols > CMP_W'(MAX_COLS)) begin
         cols = CMP_W'(MAX_COLS);
      end else begin
         cols = gcols;
      end
      if (grows < CMP_W'(WIN_ROWS)) begin
         rows = CMP_W'(WIN_ROWS);
      end else if (grows > CMP_W'(MAX_ROWS)) begin
         rows = CMP_W'(MAX_ROWS);
      end else begin
         rows = grows;
      end
   end

   assign restart  = (CMP_W'(cur_row_ff) >= rows) || (CMP_W'(cur_col_ff) >= cols);
   assign r0       = restart ? '0 : cur_row_ff;
   assign c0       = restart ? '0 : cur_col_ff;
   assign col_last = (CMP_W'(c0) + CMP_W'(1)) >= cols;
   assign row_last = (CMP_W'(r0) + CMP_W'(1)) >= rows;
   assign cell_acc = req_acc && (cmd == CMD_CELL);
   assign is_src   = (CMP_W'(r0) == CMP_W'(cfg.source_row)) &&
                     (CMP_W'(c0) == CMP_W'(cfg.source_col));
   assign emit0    = (r0 >= RW'(2 * HALO)) && (c0 >= CW'(2 * HALO));
   assign orow0    = IDX_W'(r0 - RW'(HALO));
   assign ocol0    = IDX_W'(c0 - CW'(HALO));
   assign prod_in  = PROD_W'(signed'(wavelet_sample)) * signed'({1'b0, cfg.source_scale});

   always_comb begin
      cur_col_in = cur_col_ff;
      cur_row_in = cur_row_ff;
      if (cell_acc) begin
         if (col_last) begin
            cur_col_in = '0;
            cur_row_in = row_last ? '0 : RW'(r0 + RW'(1));
         end else begin
            cur_col_in = CW'(c0 + CW'(1));
            cur_row_in = r0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_col_ff <= '0;
         cur_row_ff <= '0;
         v1_ff      <= 1'b0;
      end else begin
         cur_col_ff <= cur_col_in;
         cur_row_ff <= cur_row_in;
         if (adv) begin
            v1_ff <= cell_acc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         e1_ff     <= emit0;
         s1_ff     <= is_src;
         c1_ff     <= c0;
         pres1_ff  <= present_sample;
         older1_ff <= older_sample;
         vel1_ff   <= velocity_factor;
         prod1_ff  <= prod_in;
         orow1_ff  <= orow0;
         ocol1_ff  <= ocol0;
      end
   end

   assign p_inj = s1_ff ? sat32(WIDE_W'(pres1_ff) + WIDE_W'(prod1_ff >>> 16)) : pres1_ff;

   // cascaded line stores: store k holds row r-1-k at each column
   for (genvar k = 0; k < LB_COUNT; k++) begin : g_line
      logic [SAMPLE_W-1:0] lb_wdata;
      if (k == 0) begin : g_first
         assign lb_wdata = p_inj;
      end else begin : g_next
         assign lb_wdata = lb_rd[k-1];
      end
      awss_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_COLS)) u_line (
         .clock   (clock),
         .wr_en   (v1_ff && adv),
         .wr_addr (c1_ff),
         .wr_data (lb_wdata),
         .rd_en   (adv),
         .rd_addr (c0),
         .rd_data (lb_rd[k])
      );
   end

   // older and velocity travel four rows behind, packed together
   for (genvar k = 0; k < DLY_COUNT; k++) begin : g_delay
      logic [2*SAMPLE_W-1:0] dl_wdata;
      if (k == 0) begin : g_first
         assign dl_wdata = {vel1_ff, older1_ff};
      end else begin : g_next
         assign dl_wdata = dl_rd[k-1];
      end
      awss_ram #(.WIDTH(2 * SAMPLE_W), .DEPTH(MAX_COLS)) u_delay (
         .clock   (clock),
         .wr_en   (v1_ff && adv),
         .wr_addr (c1_ff),
         .wr_data (dl_wdata),
         .rd_en   (adv),
         .rd_addr (c0),
         .rd_data (dl_rd[k])
      );
   end

   awss_ram #(.WIDTH(DAMP_W), .DEPTH(DAMP_TAB)) u_col_damp (
      .clock   (clock),
      .wr_en   (req_acc && (cmd == CMD_COL_DAMP)),
      .wr_addr (table_index),
      .wr_data (damp_value),
      .rd_en   (adv),
      .rd_addr (ocol0),
      .rd_data (col_rd)
   );

   awss_ram #(.WIDTH(DAMP_W), .DEPTH(DAMP_TAB)) u_row_damp (
      .clock   (clock),
      .wr_en   (req_acc && (cmd == CMD_ROW_DAMP)),
      .wr_addr (table_index),
      .wr_data (damp_value),
      .rd_en   (adv),
      .rd_addr (orow0),
      .rd_data (row_rd)
   );

   always_comb begin
      cv[0] = p_inj;
      for (int k = 1; k < WIN_ROWS; k++) begin
         cv[k] = lb_rd[k-1];
      end
   end

   // column delay gives the vertical arm, row shift the horizontal arm
   always_ff @(posedge clock) begin
      if (v1_ff && adv) begin
         vd_ff[0] <= cv;
         h_ff[0]  <= cv[HALO];
         od_ff[0] <= dl_rd[DLY_COUNT-1];
         for (int i = 1; i < DLY_COUNT; i++) begin
            vd_ff[i] <= vd_ff[i-1];
            od_ff[i] <= od_ff[i-1];
         end
         for (int i = 1; i < LB_COUNT; i++) begin
            h_ff[i] <= h_ff[i-1];
         end
      end
   end

   always_comb begin
      win_in          = win_ff;
      win_in.valid    = v1_ff && e1_ff;
      win_in.row      = orow1_ff;
      win_in.col      = ocol1_ff;
      win_in.horz[0]  = cv[HALO];
      for (int i = 0; i < WIN_ROWS; i++) begin
         win_in.vert[i] = vd_ff[DLY_COUNT-1][i];
      end
      for (int i = 0; i < LB_COUNT; i++) begin
         win_in.horz[i+1] = h_ff[i];
      end
      win_in.centre   = vd_ff[DLY_COUNT-1][HALO];
      win_in.older    = od_ff[DLY_COUNT-1][SAMPLE_W-1:0];
      win_in.velocity = od_ff[DLY_COUNT-1][2*SAMPLE_W-1:SAMPLE_W];
      win_in.col_damp = col_rd;
      win_in.row_damp = row_rd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff.valid <= 1'b0;
      end else if (adv) begin
         win_ff <= win_in;
      end
   end

   assign win = win_ff;

   `AWSS_ASSERT(a_cell_enters, cell_acc |=> v1_ff, "accepted cell did not reach first stage")
   `AWSS_ASSERT(a_win_source, $rose(win_ff.valid) |-> $past(v1_ff && e1_ff),
                "window valid without an interior cell")

endmodule

[rtl/awss_calc.sv]
// arithmetic pipeline: stencil sum, laplacian scale, update, damping, saturation
// depends on awss_pkg and assert_macros.svh
`include "assert_macros.svh"
module awss_calc import awss_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                adv,
   input  window_type          win,
   input  logic [SAMPLE_W-1:0] lap_scale,
   output logic                out_valid,
   output logic [IDX_W-1:0]    out_row,
   output logic [IDX_W-1:0]    out_col,
   output logic [SAMPLE_W-1:0] new_present,
   output logic [SAMPLE_W-1:0] new_older
);

   logic v3_ff, v4_ff, v5_ff, v6_ff, v7_ff, v8_ff, v9_ff, out_v_ff;

   // side data carried along the stages
   logic [IDX_W-1:0]    row3_ff, row4_ff, row5_ff, row6_ff, row7_ff, row8_ff, row9_ff;
   logic [IDX_W-1:0]    col3_ff, col4_ff, col5_ff, col6_ff, col7_ff, col8_ff, col9_ff;
   sample_type          pc3_ff, pc4_ff, pc5_ff, pc6_ff, pc7_ff, pc8_ff;
   sample_type          older3_ff, older4_ff, older5_ff;
   logic [SAMPLE_W-1:0] vel3_ff, vel4_ff, vel5_ff, vel6_ff;
   logic [SAMPLE_W-1:0] damp3_ff, damp4_ff, damp5_ff, damp6_ff, damp7_ff, damp8_ff;

   logic signed [TERM_W-1:0] tv_ff [NPAIR];
   logic signed [TERM_W-1:0] th_ff [NPAIR];
   logic signed [TERM_W-1:0] tv_in [NPAIR];
   logic signed [TERM_W-1:0] th_in [NPAIR];
   logic signed [SUM_W-1:0]  sum4_ff, sum4_in;
   logic signed [LAPP_W-1:0] php5_ff, plo5_ff;
   sample_type               lap6_ff;
   logic signed [TPO_W-1:0]  tpo6_ff, tpo7_ff;
   logic signed [PROD_W-1:0] term7_ff;
   sample_type               past8_ff;
   logic signed [PROD_W-1:0] np9_ff, no9_ff;
   logic [IDX_W-1:0]         row_out_ff, col_out_ff;
   sample_type               np_out_ff, no_out_ff;

   // symmetric pairs share one constant product
   always_comb begin
      for (int k = 0; k < NPAIR; k++) begin
         logic signed [PAIR_W-1:0] pv, ph;
         if (k < HALO) begin
            pv = PAIR_W'(signed'(win.vert[k])) + PAIR_W'(signed'(win.vert[2*HALO-k]));
            ph = PAIR_W'(signed'(win.horz[k])) + PAIR_W'(signed'(win.horz[2*HALO-k]));
         end else begin
            pv = PAIR_W'(signed'(win.vert[HALO]));
            ph = PAIR_W'(signed'(win.horz[HALO]));
         end
         tv_in[k] = TERM_W'(pv) * TERM_W'(stencil_coef(k));
         th_in[k] = TERM_W'(ph) * TERM_W'(stencil_coef(k));
      end
   end

   always_comb begin
      sum4_in = '0;
      for (int k = 0; k < NPAIR; k++) begin
         sum4_in = sum4_in + SUM_W'(tv_ff[k]) + SUM_W'(th_ff[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff    <= 1'b0;
         v4_ff    <= 1'b0;
         v5_ff    <= 1'b0;
         v6_ff    <= 1'b0;
         v7_ff    <= 1'b0;
         v8_ff    <= 1'b0;
         v9_ff    <= 1'b0;
         out_v_ff <= 1'b0;
      end else if (adv) begin
         v3_ff    <= win.valid;
         v4_ff    <= v3_ff;
         v5_ff    <= v4_ff;
         v6_ff    <= v5_ff;
         v7_ff    <= v6_ff;
         v8_ff    <= v7_ff;
         v9_ff    <= v8_ff;
         out_v_ff <= v9_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         // constant products
         tv_ff     <= tv_in;
         th_ff     <= th_in;
         damp3_ff  <= win.col_damp * win.row_damp;
         row3_ff   <= win.row;
         col3_ff   <= win.col;
         pc3_ff    <= win.centre;
         older3_ff <= win.older;
         vel3_ff   <= win.velocity;
         // stencil sum
         sum4_ff   <= sum4_in;
         row4_ff   <= row3_ff;
         col4_ff   <= col3_ff;
         pc4_ff    <= pc3_ff;
         older4_ff <= older3_ff;
         vel4_ff   <= vel3_ff;
         damp4_ff  <= damp3_ff;
         // laplacian scale split into integer and fraction halves
         php5_ff   <= sum4_ff * signed'({1'b0, lap_scale[SAMPLE_W-1:16]});
         plo5_ff   <= sum4_ff * signed'({1'b0, lap_scale[15:0]});
         row5_ff   <= row4_ff;
         col5_ff   <= col4_ff;
         pc5_ff    <= pc4_ff;
         older5_ff <= older4_ff;
         vel5_ff   <= vel4_ff;
         damp5_ff  <= damp4_ff;
         lap6_ff   <= sat32(WIDE_W'(php5_ff) + WIDE_W'(plo5_ff >>> 16));
         tpo6_ff   <= (TPO_W'(pc5_ff) <<< 1) - TPO_W'(older5_ff);
         row6_ff   <= row5_ff;
         col6_ff   <= col5_ff;
         pc6_ff    <= pc5_ff;
         vel6_ff   <= vel5_ff;
         damp6_ff  <= damp5_ff;
         // velocity term
         term7_ff  <= PROD_W'(lap6_ff) * signed'({1'b0, vel6_ff});
         tpo7_ff   <= tpo6_ff;
         row7_ff   <= row6_ff;
         col7_ff   <= col6_ff;
         pc7_ff    <= pc6_ff;
         damp7_ff  <= damp6_ff;
         past8_ff  <= sat32(WIDE_W'(term7_ff >>> 16) + WIDE_W'(tpo7_ff));
         row8_ff   <= row7_ff;
         col8_ff   <= col7_ff;
         pc8_ff    <= pc7_ff;
         damp8_ff  <= damp7_ff;
         // damping, q2.30
         np9_ff    <= PROD_W'(past8_ff) * signed'({1'b0, damp8_ff});
         no9_ff    <= PROD_W'(pc8_ff) * signed'({1'b0, damp8_ff});
         row9_ff   <= row8_ff;
         col9_ff   <= col8_ff;
         np_out_ff  <= sat32(WIDE_W'(np9_ff >>> 30));
         no_out_ff  <= sat32(WIDE_W'(no9_ff >>> 30));
         row_out_ff <= row9_ff;
         col_out_ff <= col9_ff;
      end
   end

   assign out_valid   = out_v_ff;
   assign out_row     = row_out_ff;
   assign out_col     = col_out_ff;
   assign new_present = np_out_ff;
   assign new_older   = no_out_ff;

   `AWSS_ASSERT(a_out_origin, $rose(out_v_ff) |-> $past(v9_ff), "result without a last-stage item")
   `AWSS_ASSERT(a_last_moves, (v9_ff && adv) |=> out_v_ff, "last-stage item lost on advance")

endmodule

[rtl/acoustic_wave_stencil_step.sv]
// top level of the streaming acoustic wave stencil step
// depends on awss_pkg, awss_front, awss_calc (and through them awss_ram)
//
// channel   dir  handshake              payload
// req       in   req_tvalid/req_tready  tuser cmd, tdata cell and damping fields
// rsp       out  rsp_tvalid/rsp_tready  tdata row, col, new present, new older
// csr       in   csr_valid/csr_ready    csr_index, csr_wdata
//
// one transaction per cycle when rsp_tready stays high; a result leaves with the input
// of the grid cell four rows and four columns past it, after passing the line-store read
// stage, the window stage and eight arithmetic stages
// the whole pipe advances together; a stalled output freezes every stage and req_tready
// reset is synchronous and clears position, valid bits and configuration
// line stores and damping tables are not cleared and hold nothing useful until written
module acoustic_wave_stencil_step import awss_pkg::*; #(
   parameter int MAX_COLS = MAX_COLS_DEF,
   parameter int MAX_ROWS = MAX_ROWS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // tdata: table_index, damp_value, present_sample, older_sample, velocity_factor,
   //        wavelet_sample, zero fill
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // tuser: cmd
   input  logic [CMD_W-1:0]      req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // tdata: out_row, out_col, new_present, new_older, zero fill
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type             cfg_ff;
   logic                adv, req_acc;
   window_type          win;
   logic [IDX_W-1:0]    out_row, out_col;
   logic [SAMPLE_W-1:0] new_present, new_older;

   assign adv        = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;
   assign req_acc    = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.grid_cols    <= RESET_GRID;
         cfg_ff.grid_rows    <= RESET_GRID;
         cfg_ff.source_row   <= '0;
         cfg_ff.source_col   <= '0;
         cfg_ff.source_scale <= RESET_SCALE;
         cfg_ff.lap_scale    <= RESET_SCALE;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_GRID_COLS:  cfg_ff.grid_cols    <= csr_wdata[SIZE_W-1:0];
            REG_GRID_ROWS:  cfg_ff.grid_rows    <= csr_wdata[SIZE_W-1:0];
            REG_SOURCE_ROW: cfg_ff.source_row   <= csr_wdata[IDX_W-1:0];
            REG_SOURCE_COL: cfg_ff.source_col   <= csr_wdata[IDX_W-1:0];
            REG_SOURCE_SCL: cfg_ff.source_scale <= csr_wdata;
            REG_LAP_SCL:    cfg_ff.lap_scale    <= csr_wdata;
            default: ;
         endcase
      end
   end

   awss_front #(.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS)) u_front (
      .clock           (clock),
      .reset           (reset),
      .adv             (adv),
      .req_acc         (req_acc),
      .cmd             (req_tuser),
      .table_index     (req_tdata[9:0]),
      .damp_value      (req_tdata[25:10]),
      .present_sample  (req_tdata[57:26]),
      .older_sample    (req_tdata[89:58]),
      .velocity_factor (req_tdata[121:90]),
      .wavelet_sample  (req_tdata[153:122]),
      .cfg             (cfg_ff),
      .win             (win)
   );

   awss_calc u_calc (
      .clock       (clock),
      .reset       (reset),
      .adv         (adv),
      .win         (win),
      .lap_scale   (cfg_ff.lap_scale),
      .out_valid   (rsp_tvalid),
      .out_row     (out_row),
      .out_col     (out_col),
      .new_present (new_present),
      .new_older   (new_older)
   );

   assign rsp_tdata = {4'b0, new_older, new_present, out_col, out_row};

endmodule
